/* rtl/core/fcc_pkg.sv */
// Package with the shared constants, codes and sequencer states of the floor and ceiling caster.
package fcc_pkg;

  // Default geometry of the texture and the screen.
  localparam int TEX_WIDTH_DEF         = 64;
  localparam int TEX_HEIGHT_DEF        = 64;
  localparam int MAX_SCREEN_WIDTH_DEF  = 2048;
  localparam int MAX_SCREEN_HEIGHT_DEF = 2048;

  // Texel store depth and index width.
  localparam int TEXEL_DEPTH = 4096;
  localparam int TEXEL_AW    = 12;

  // Stream payload widths.
  localparam int IN_DATA_W  = 248;
  localparam int OUT_DATA_W = 112;

  // Item kinds carried in tuser.
  localparam logic [1:0] ACT_WR_FLOOR   = 2'd0;
  localparam logic [1:0] ACT_WR_CEILING = 2'd1;
  localparam logic [1:0] ACT_START_ROW  = 2'd2;
  localparam logic [1:0] ACT_PIXEL      = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_FLOOR_COLOR   = 3'd2;
  localparam logic [2:0] CFG_CEILING_COLOR = 3'd3;
  localparam logic [2:0] CFG_TEXTURE_MODE  = 3'd4;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PIX,
    S_DIV_DIST,
    S_MUL_LOAD,
    S_MUL,
    S_DIV_STEP,
    S_NEG,
    S_STORE
  } state_t;

endpackage

/* rtl/core/floor_ceiling_texture_caster_top.sv */
// Floor and ceiling caster: texel stores, row setup sequencer and pixel output stage.
//
// A texel write item leaves the block ready for the next item. A pixel item reads
// both texel stores as it is taken, then waits for the output register to be free
// and loads it; no new item is taken before that. A start-row item runs a sequencer
// over one shared 64-bit add/subtract unit that does bit-serial division and
// shift-add multiplication to find the row distance (skipped on the centre row), the
// two start-point products and the two column steps (multiply plus division by the
// screen width). The block takes no item while the sequencer runs; configuration
// writes are always taken.
module floor_ceiling_texture_caster_top
  import fcc_pkg::*;
#(
  parameter int TEX_WIDTH         = TEX_WIDTH_DEF,
  parameter int TEX_HEIGHT        = TEX_HEIGHT_DEF,
  parameter int MAX_SCREEN_WIDTH  = MAX_SCREEN_WIDTH_DEF,
  parameter int MAX_SCREEN_HEIGHT = MAX_SCREEN_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // texel_index, texel_color, row, pos_x, pos_y, dir_x, dir_y, plane_x, plane_y
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // action
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // floor_pixel_addr, floor_pixel_color, ceiling_pixel_addr, ceiling_pixel_color
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // last_in_row
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  // Configuration registers.
  logic [11:0] screen_width;
  logic [11:0] screen_height;
  logic [31:0] floor_color;
  logic [31:0] ceiling_color;
  logic [1:0]  texture_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 12'd640;
      screen_height <= 12'd480;
      floor_color   <= '0;
      ceiling_color <= '0;
      texture_mode  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data[11:0];
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data[11:0];
        CFG_FLOOR_COLOR:   floor_color   <= cfg_data;
        CFG_CEILING_COLOR: ceiling_color <= cfg_data;
        CFG_TEXTURE_MODE:  texture_mode  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Effective width and height after clamping.
  logic [11:0] w_eff;
  logic [11:0] h_eff;

  always_comb begin
    w_eff = screen_width;
    if (screen_width == 12'd0) begin
      w_eff = 12'd1;
    end else if (32'(screen_width) > MAX_SCREEN_WIDTH) begin
      w_eff = 12'(MAX_SCREEN_WIDTH);
    end
    h_eff = screen_height;
    if (32'(screen_height) > MAX_SCREEN_HEIGHT) begin
      h_eff = 12'(MAX_SCREEN_HEIGHT);
    end
  end

  // Input field unpacking.
  logic [1:0]  in_action;
  logic [11:0] in_texel_index;
  logic [31:0] in_texel_color;
  logic [10:0] in_row;
  logic [31:0] in_pos_x, in_pos_y, in_dir_x, in_dir_y, in_plane_x, in_plane_y;

  assign in_action      = s_axis_tuser;
  assign in_texel_index = s_axis_tdata[11:0];
  assign in_texel_color = s_axis_tdata[43:12];
  assign in_row         = s_axis_tdata[54:44];
  assign in_pos_x       = s_axis_tdata[86:55];
  assign in_pos_y       = s_axis_tdata[118:87];
  assign in_dir_x       = s_axis_tdata[150:119];
  assign in_dir_y       = s_axis_tdata[182:151];
  assign in_plane_x     = s_axis_tdata[214:183];
  assign in_plane_y     = s_axis_tdata[246:215];

  state_t state, state_next;

  logic accept;
  logic acc_row;
  logic acc_pix;

  assign s_axis_tready = (state == S_IDLE);
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign acc_row = accept && (in_action == ACT_START_ROW);
  assign acc_pix = accept && (in_action == ACT_PIXEL);

  // Texel stores with registered read.
  logic [31:0] floor_texels   [TEXEL_DEPTH];
  logic [31:0] ceiling_texels [TEXEL_DEPTH];
  logic [31:0] floor_q;
  logic [31:0] ceiling_q;
  logic [TEXEL_AW-1:0] tex_idx;

  always_ff @(posedge clk) begin
    if (accept && (in_action == ACT_WR_FLOOR)) begin
      floor_texels[in_texel_index] <= in_texel_color;
    end
    if (acc_pix) begin
      floor_q <= floor_texels[tex_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_action == ACT_WR_CEILING)) begin
      ceiling_texels[in_texel_index] <= in_texel_color;
    end
    if (acc_pix) begin
      ceiling_q <= ceiling_texels[tex_idx];
    end
  end

  // Row and walk state.
  logic [31:0] world_x, world_y, step_x, step_y;
  logic [10:0] column;
  logic [10:0] current_row;

  // Texel coordinates from the fraction bits of the world point.
  logic [31:0] tx_prod, ty_prod, idx_full;

  always_comb begin
    tx_prod  = 32'(world_x[15:0]) * 32'(TEX_WIDTH);
    ty_prod  = 32'(world_y[15:0]) * 32'(TEX_HEIGHT);
    idx_full = 32'(TEX_WIDTH) * 32'(ty_prod[31:16]) + 32'(tx_prod[31:16]);
    tex_idx  = idx_full[TEXEL_AW-1:0];
  end

  // Frame addresses and the last-column flag of the pixel being accepted.
  logic [21:0] faddr_calc, caddr_calc, crow_calc;
  logic [10:0] wm1;
  logic        last_calc;

  always_comb begin
    faddr_calc = 22'(current_row) * 22'(w_eff) + 22'(column);
    crow_calc  = 22'(h_eff) - 22'(current_row) - 22'd1;
    caddr_calc = crow_calc * 22'(w_eff) + 22'(column);
    wm1        = 11'(w_eff - 12'd1);
    last_calc  = (column == wm1);
  end

  logic [21:0] pend_faddr, pend_caddr;
  logic        pend_last;

  always_ff @(posedge clk) begin
    if (acc_pix) begin
      pend_faddr <= faddr_calc;
      pend_caddr <= caddr_calc;
      pend_last  <= last_calc;
    end
  end

  // Sequencer datapath registers.
  logic [5:0]  cnt;
  logic [1:0]  k;
  logic [63:0] acc;
  logic [47:0] dq;
  logic [63:0] dvs;
  logic [30:0] dist_mag;
  logic        dist_neg;
  logic        prod_neg;
  logic [31:0] pos_x, pos_y;
  logic [32:0] ray_x, ray_y, pl_x, pl_y;

  // Row offset from the screen centre.
  logic [12:0] p_val, p_mag;

  always_comb begin
    p_val = {2'b00, in_row} - {2'b00, h_eff[11:1]};
    p_mag = p_val[12] ? (13'd0 - p_val) : p_val;
  end

  // Multiplier operand for the current product.
  logic [32:0] mop, mop_mag;

  always_comb begin
    case (k)
      2'd0:    mop = ray_x;
      2'd1:    mop = ray_y;
      2'd2:    mop = pl_x;
      default: mop = pl_y;
    endcase
    mop_mag = mop[32] ? (33'd0 - mop) : mop;
  end

  // Shared add/subtract unit.
  logic [63:0] alu_a, alu_b;
  logic        alu_sub;
  logic [64:0] alu_y;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      S_DIV_DIST, S_DIV_STEP: begin
        alu_a   = {acc[62:0], dq[47]};
        alu_b   = dvs;
        alu_sub = 1'b1;
      end
      S_MUL: begin
        alu_a = {acc[62:0], 1'b0};
        alu_b = dq[47] ? 64'(dist_mag) : 64'd0;
      end
      S_NEG: begin
        alu_b   = acc;
        alu_sub = 1'b1;
      end
      S_STORE: begin
        alu_a = (k == 2'd0) ? 64'($signed(pos_x)) : 64'($signed(pos_y));
        alu_b = 64'(acc[47:16]);
      end
      default: ;
    endcase
    alu_y = {1'b0, alu_a} + {1'b0, alu_sub ? ~alu_b : alu_b} + 65'(alu_sub);
  end

  // One restoring division step.
  logic [63:0] div_rem;
  logic [47:0] div_dq;

  always_comb begin
    div_rem = alu_y[64] ? alu_y[63:0] : alu_a;
    div_dq  = {dq[46:0], alu_y[64]};
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc_pix) begin
          state_next = S_PIX;
        end else if (acc_row) begin
          state_next = (p_val == 13'd0) ? S_MUL_LOAD : S_DIV_DIST;
        end
      end
      S_PIX: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = S_IDLE;
        end
      end
      S_DIV_DIST: begin
        if (cnt == 6'd0) begin
          state_next = S_MUL_LOAD;
        end
      end
      S_MUL_LOAD: state_next = S_MUL;
      S_MUL: begin
        if (cnt == 6'd0) begin
          state_next = k[1] ? S_DIV_STEP : S_NEG;
        end
      end
      S_DIV_STEP: begin
        if (cnt == 6'd0) begin
          state_next = S_NEG;
        end
      end
      S_NEG:   state_next = S_STORE;
      S_STORE: state_next = (k == 2'd3) ? S_IDLE : S_MUL_LOAD;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      k   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc_row) begin
            k   <= 2'd0;
            cnt <= 6'd47;
          end
        end
        S_DIV_DIST, S_DIV_STEP: begin
          cnt <= cnt - 6'd1;
        end
        S_MUL_LOAD: cnt <= 6'd32;
        S_MUL: begin
          cnt <= (cnt == 6'd0) ? 6'd47 : (cnt - 6'd1);
        end
        S_STORE: k <= k + 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (acc_row) begin
          pos_x    <= in_pos_x;
          pos_y    <= in_pos_y;
          ray_x    <= 33'($signed(in_dir_x)) - 33'($signed(in_plane_x));
          ray_y    <= 33'($signed(in_dir_y)) - 33'($signed(in_plane_y));
          pl_x     <= 33'($signed(in_plane_x));
          pl_y     <= 33'($signed(in_plane_y));
          dq       <= 48'({h_eff, 15'd0});
          acc      <= '0;
          dvs      <= 64'(p_mag);
          dist_neg <= p_val[12];
          dist_mag <= 31'h7FFF_FFFF;
        end
      end
      S_DIV_DIST: begin
        acc <= div_rem;
        dq  <= div_dq;
        if (cnt == 6'd0) begin
          dist_mag <= div_dq[30:0];
        end
      end
      S_MUL_LOAD: begin
        dq       <= {mop_mag, 15'd0};
        acc      <= '0;
        prod_neg <= dist_neg ^ mop[32];
      end
      S_MUL: begin
        if ((cnt == 6'd0) && k[1]) begin
          // Hand the product magnitude over to the step division.
          dq  <= alu_y[62:15];
          acc <= '0;
          dvs <= 64'(w_eff);
        end else begin
          acc <= alu_y[63:0];
          dq  <= {dq[46:0], 1'b0};
        end
      end
      S_DIV_STEP: begin
        acc <= div_rem;
        dq  <= div_dq;
        if (cnt == 6'd0) begin
          acc <= 64'(div_dq);
        end
      end
      S_NEG: begin
        if (prod_neg) begin
          acc <= alu_y[63:0];
        end
      end
      default: ;
    endcase
  end

  // World point, steps, column and row.
  always_ff @(posedge clk) begin
    if (rst) begin
      world_x     <= '0;
      world_y     <= '0;
      step_x      <= '0;
      step_y      <= '0;
      column      <= '0;
      current_row <= '0;
    end else begin
      if (acc_row) begin
        current_row <= in_row;
        column      <= '0;
      end else if (acc_pix) begin
        world_x <= world_x + step_x;
        world_y <= world_y + step_y;
        column  <= last_calc ? 11'd0 : (column + 11'd1);
      end
      if (state == S_STORE) begin
        case (k)
          2'd0:    world_x <= alu_y[31:0];
          2'd1:    world_y <= alu_y[31:0];
          2'd2:    step_x  <= acc[31:0];
          default: step_y  <= acc[31:0];
        endcase
      end
    end
  end

  // Output register.
  logic load_out;
  assign load_out = (state == S_PIX) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= {4'd0,
                       texture_mode[1] ? ceiling_q : ceiling_color,
                       pend_caddr,
                       texture_mode[0] ? floor_q : floor_color,
                       pend_faddr};
      m_axis_tlast <= pend_last;
    end
  end

  // A pixel item always goes to the texel read stage.
  a_pix_stage: assert property (@(posedge clk) disable iff (rst)
    acc_pix |=> (state == S_PIX))
    else $error("pixel item did not enter the read stage");

  // A start-row item blocks further items while the setup runs.
  a_row_busy: assert property (@(posedge clk) disable iff (rst)
    acc_row |=> !s_axis_tready)
    else $error("block ready during row setup");

  // The last store of the setup returns the sequencer to idle.
  a_setup_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_STORE) && (k == 2'd3) |=> (state == S_IDLE))
    else $error("row setup did not finish after the last step store");

endmodule
